>>> rtl/core/assert_macros.svh
// Assertion macros for the checker module of the project.
// Needs nothing else; every use names a clock, and ASSERT_CLK also a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Check a property on the rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

>>> rtl/core/pipr_pkg.sv
// Package for the point-in-polygon ray-cast block: widths, reset values
// and the flag bundle that travels from the edge evaluator to the top level.
// Depends on nothing.
`default_nettype none

package pipr_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int TOL_WIDTH   = 16;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;
  localparam int EDGE_FIELDS = 6;
  localparam int OUT_DATA_WIDTH = 8;

  typedef struct packed {
    logic in_span;
    logic vertical;
    logic dy_pos;
    logic dy_neg;
  } edge_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/point_in_polygon_ray_cast.sv
// Top level of the even-odd ray-cast point-in-polygon test.
// Depends on pipr_pkg and pipr_edge_eval.
//
// Feed one polygon edge per transaction together with the query point; mark
// the polygon's final edge with s_tlast. The block takes one edge every
// cycle while its input is not stalled and answers once per polygon, on its
// last edge, with m_tdata[0] high when the point lies inside. An edge passes
// through an input register, a product register (the two cross
// multiplications of the crossing test) and the result register. Only the
// one-bit crossing parity is carried from edge to edge. Edges that produce
// no answer keep flowing while an answer waits to be taken; input stalls
// only when a last edge reaches a full result register. Write
// vertical_tolerance through cfg_wr_en and cfg_wr_data while no polygon is
// in flight; it resets to 1.
`default_nettype none

module point_in_polygon_ray_cast #(
  parameter int CoordWidth = pipr_pkg::COORD_WIDTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [pipr_pkg::TOL_WIDTH-1:0]         cfg_wr_data,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // query_x, query_y, edge_start_x, edge_start_y, edge_end_x, edge_end_y
  input  wire logic [((pipr_pkg::EDGE_FIELDS*CoordWidth+7)/8)*8-1:0] s_tdata,
  // last_edge
  input  wire logic                                   s_tlast,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // inside_res
  output logic [pipr_pkg::OUT_DATA_WIDTH-1:0]         m_tdata
);

  localparam int FieldBits = pipr_pkg::EDGE_FIELDS * CoordWidth;
  localparam int ProdW     = 2 * (CoordWidth + 1);

  logic [pipr_pkg::TOL_WIDTH-1:0] vertical_tolerance;

  logic                 s0_valid;
  logic                 s0_last;
  logic [FieldBits-1:0] s0_data;

  logic                        s1_valid;
  logic                        s1_last;
  pipr_pkg::edge_flags_t       s1_flags;
  logic signed [ProdW-1:0]     s1_prod_a;
  logic signed [ProdW-1:0]     s1_prod_b;

  logic                        crossing_parity;
  logic                        inside_res;

  pipr_pkg::edge_flags_t       eval_flags;
  logic signed [ProdW-1:0]     eval_prod_a;
  logic signed [ProdW-1:0]     eval_prod_b;

  logic out_free;
  logic s1_go;
  logic s1_free;
  logic s0_go;
  logic crosses;

  pipr_edge_eval #(
    .CoordWidth(CoordWidth)
  ) u_eval (
    .query_x      (s0_data[0*CoordWidth +: CoordWidth]),
    .query_y      (s0_data[1*CoordWidth +: CoordWidth]),
    .edge_start_x (s0_data[2*CoordWidth +: CoordWidth]),
    .edge_start_y (s0_data[3*CoordWidth +: CoordWidth]),
    .edge_end_x   (s0_data[4*CoordWidth +: CoordWidth]),
    .edge_end_y   (s0_data[5*CoordWidth +: CoordWidth]),
    .tolerance    (vertical_tolerance),
    .flags        (eval_flags),
    .prod_a       (eval_prod_a),
    .prod_b       (eval_prod_b)
  );

  always_comb begin
    out_free = !m_tvalid || m_tready;
    s1_go    = s1_valid && (!s1_last || out_free);
    s1_free  = !s1_valid || s1_go;
    s0_go    = s0_valid && s1_free;
    s_tready = !s0_valid || s0_go;

    crosses = s1_flags.in_span &&
              (s1_flags.vertical ||
               (s1_flags.dy_pos && (s1_prod_a <= s1_prod_b)) ||
               (s1_flags.dy_neg && (s1_prod_b <= s1_prod_a)));

    m_tdata = {{(pipr_pkg::OUT_DATA_WIDTH-1){1'b0}}, inside_res};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_tolerance <= pipr_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      vertical_tolerance <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s_tready) begin
      s0_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      s0_data <= s_tdata[FieldBits-1:0];
      s0_last <= s_tlast;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s0_valid;
    end
    if (s0_go) begin
      s1_last   <= s0_last;
      s1_flags  <= eval_flags;
      s1_prod_a <= eval_prod_a;
      s1_prod_b <= eval_prod_b;
    end
  end

  // Parity and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_parity <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (s1_go && s1_last) begin
        m_tvalid        <= 1'b1;
        crossing_parity <= 1'b0;
      end else begin
        if (m_tvalid && m_tready) begin
          m_tvalid <= 1'b0;
        end
        if (s1_go) begin
          crossing_parity <= crossing_parity ^ crosses;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      inside_res <= crossing_parity ^ crosses;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pipr_edge_eval.sv
// Edge evaluator: span checks, vertical test and the two cross products
// of the even-odd crossing test for one edge. Uses pipr_pkg.
`default_nettype none

module pipr_edge_eval #(
  parameter int CoordWidth = pipr_pkg::COORD_WIDTH
) (
  input  wire logic signed [CoordWidth-1:0]        query_x,
  input  wire logic signed [CoordWidth-1:0]        query_y,
  input  wire logic signed [CoordWidth-1:0]        edge_start_x,
  input  wire logic signed [CoordWidth-1:0]        edge_start_y,
  input  wire logic signed [CoordWidth-1:0]        edge_end_x,
  input  wire logic signed [CoordWidth-1:0]        edge_end_y,
  input  wire logic [pipr_pkg::TOL_WIDTH-1:0]      tolerance,
  output pipr_pkg::edge_flags_t                    flags,
  output logic signed [2*(CoordWidth+1)-1:0]       prod_a,
  output logic signed [2*(CoordWidth+1)-1:0]       prod_b
);

  localparam int DiffW = CoordWidth + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int CmpW  = (DiffW > pipr_pkg::TOL_WIDTH) ? DiffW : pipr_pkg::TOL_WIDTH;

  logic signed [DiffW-1:0]      dx;
  logic signed [DiffW-1:0]      dy;
  logic signed [DiffW-1:0]      rel_x;
  logic signed [DiffW-1:0]      rel_y;
  logic        [DiffW-1:0]      dx_mag;
  logic signed [CoordWidth-1:0] max_x;
  logic signed [CoordWidth-1:0] min_y;
  logic signed [CoordWidth-1:0] max_y;

  always_comb begin
    dx     = DiffW'(edge_end_x) - DiffW'(edge_start_x);
    dy     = DiffW'(edge_end_y) - DiffW'(edge_start_y);
    rel_x  = DiffW'(query_x) - DiffW'(edge_start_x);
    rel_y  = DiffW'(query_y) - DiffW'(edge_start_y);
    dx_mag = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);

    max_x = (edge_start_x < edge_end_x) ? edge_end_x : edge_start_x;
    min_y = (edge_start_y < edge_end_y) ? edge_start_y : edge_end_y;
    max_y = (edge_start_y < edge_end_y) ? edge_end_y : edge_start_y;

    flags.in_span  = (query_y >= min_y) && (query_y <= max_y) && (query_x <= max_x);
    flags.vertical = CmpW'(dx_mag) < CmpW'(tolerance);
    flags.dy_neg   = dy[DiffW-1];
    flags.dy_pos   = !dy[DiffW-1] && (dy != '0);

    prod_a = ProdW'(rel_x) * ProdW'(dy);
    prod_b = ProdW'(rel_y) * ProdW'(dx);
  end

endmodule

`default_nettype wire

>>> rtl/core/pipr_checker.sv
// Port-level checks for point_in_polygon_ray_cast, attached by bind.
// Depends on pipr_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module pipr_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [pipr_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);

  `ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_tvalid)
  `ASSERT_CLK(a_out_holds, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `ASSERT_CLK(a_stall_from_out, clk, rst, !s_tready |-> m_tvalid && !m_tready)
  `ASSERT_CLK(a_pad_zero, clk, rst, m_tvalid |-> m_tdata[pipr_pkg::OUT_DATA_WIDTH-1:1] == '0)

endmodule

bind point_in_polygon_ray_cast pipr_checker u_pipr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/pip_answer_checker.sv
// Checker for the ray-cast point-in-polygon block: watches the edge, answer
// and register-write channels, predicts each polygon's answer and compares.
// Depends on pipr_pkg.
`timescale 1ns / 1ps

module pip_answer_checker #(
  parameter int CW = pipr_pkg::COORD_WIDTH,
  parameter int DW = ((pipr_pkg::EDGE_FIELDS * pipr_pkg::COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [pipr_pkg::TOL_WIDTH-1:0]      cfg_wr_data,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [DW-1:0]                       s_tdata,
  input  logic                                s_tlast,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [pipr_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  answers_checked
);

  logic [pipr_pkg::TOL_WIDTH-1:0] tolerance;
  logic                           parity;
  logic                           inside_expected_q[$];

  function automatic logic ray_crosses_edge(
    input logic signed [CW-1:0]          qx, qy, sx, sy, ex, ey,
    input logic [pipr_pkg::TOL_WIDTH-1:0] tol
  );
    longint qxl, qyl, sxl, syl, exl, eyl, tl;
    longint max_x, min_y, max_y, dx, dy, adx;
    qxl = qx;
    qyl = qy;
    sxl = sx;
    syl = sy;
    exl = ex;
    eyl = ey;
    tl = tol;
    max_x = (sxl < exl) ? exl : sxl;
    min_y = (syl < eyl) ? syl : eyl;
    max_y = (syl < eyl) ? eyl : syl;
    dx = exl - sxl;
    dy = eyl - syl;
    adx = (dx < 0) ? -dx : dx;
    if (qyl < min_y || qyl > max_y || qxl > max_x) return 1'b0;
    if (adx < tl) return 1'b1;
    if (dy > 0) return ((qxl - sxl) * dy) <= ((qyl - syl) * dx);
    if (dy < 0) return ((qyl - syl) * dx) <= ((qxl - sxl) * dy);
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    logic signed [CW-1:0]               qx, qy, sx, sy, ex, ey;
    logic                               want;
    logic [pipr_pkg::OUT_DATA_WIDTH-1:0] want_word;
    if (rst) begin
      tolerance = pipr_pkg::TOL_RESET;
      parity = 1'b0;
      inside_expected_q.delete();
      mismatches = 0;
      outstanding = 0;
      answers_checked = 0;
    end else begin
      if (cfg_wr_en) begin
        tolerance = cfg_wr_data;
      end
      if (m_tvalid && m_tready) begin
        if (inside_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: answer with no polygon pending, m_tdata=0x%0h", $realtime, m_tdata);
          end
        end else begin
          want = inside_expected_q.pop_front();
          want_word = '0;
          want_word[0] = want;
          answers_checked++;
          if (m_tdata !== want_word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: answer %0d mismatch, expected m_tdata=0x%0h, got 0x%0h",
                       $realtime, answers_checked, want_word, m_tdata);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        qx = s_tdata[0*CW +: CW];
        qy = s_tdata[1*CW +: CW];
        sx = s_tdata[2*CW +: CW];
        sy = s_tdata[3*CW +: CW];
        ex = s_tdata[4*CW +: CW];
        ey = s_tdata[5*CW +: CW];
        if (ray_crosses_edge(qx, qy, sx, sy, ex, ey, tolerance)) begin
          parity = ~parity;
        end
        if (s_tlast) begin
          inside_expected_q.push_back(parity);
          parity = 1'b0;
        end
      end
      outstanding = inside_expected_q.size();
    end
  end

endmodule

>>> tb/point_in_polygon_ray_cast_tb.sv
// Testbench top for point_in_polygon_ray_cast: drives edge transactions,
// register writes and answer backpressure; pip_answer_checker does the checking.
// Depends on pipr_pkg, point_in_polygon_ray_cast and pip_answer_checker.
`timescale 1ns / 1ps

module point_in_polygon_ray_cast_tb;

  localparam int CW = pipr_pkg::COORD_WIDTH;
  localparam int DW = ((pipr_pkg::EDGE_FIELDS * CW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENT_EDGES = 150;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_wr_en = 1'b0;
  logic [pipr_pkg::TOL_WIDTH-1:0]      cfg_wr_data = '0;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [DW-1:0]                       s_tdata = '0;
  logic                                s_tlast = 1'b0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [pipr_pkg::OUT_DATA_WIDTH-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int answers_checked;

  int send_idle_pct = 6;
  int recv_stall_pct = 53;
  int edges_sent = 0;
  int polygons_sent = 0;
  int tol_writes = 0;
  int cycle_count = 0;

  point_in_polygon_ray_cast dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  pip_answer_checker #(.CW(CW), .DW(DW)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .answers_checked(answers_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d answers outstanding", cycle_count, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [CW-1:0] clamp_coord(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return CW'(v);
  endfunction

  task automatic send_edge(input logic signed [CW-1:0] qx, qy, sx, sy, ex, ey,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DW'({ey, ex, sy, sx, qy, qx});
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    edges_sent++;
    if (last) polygons_sent++;
  endtask

  task automatic wait_for_answers();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [pipr_pkg::TOL_WIDTH-1:0] value);
    wait_for_answers();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tol_writes++;
  endtask

  task automatic send_random_polygon();
    int n, span, cx, cy, qx, qy, j;
    int vx[8];
    int vy[8];
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        send_edge(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                  CW'($urandom), CW'($urandom), i == n - 1);
      end
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      case ($urandom_range(3))
        0: span = 16;
        1: span = 256;
        2: span = 4096;
        default: span = 32767;
      endcase
      cx = int'($urandom_range(65535)) - 32768;
      cy = int'($urandom_range(65535)) - 32768;
      for (int i = 0; i < n; i++) begin
        vx[i] = cx + int'($urandom_range(2 * span)) - span;
        vy[i] = cy + int'($urandom_range(2 * span)) - span;
      end
      if ($urandom_range(9) == 0) begin
        qx = vx[0];
        qy = vy[0];
      end else begin
        qx = cx + int'($urandom_range(2 * span)) - span;
        qy = cy + int'($urandom_range(2 * span)) - span;
      end
      for (int i = 0; i < n; i++) begin
        j = (i + 1) % n;
        send_edge(clamp_coord(qx), clamp_coord(qy), clamp_coord(vx[i]), clamp_coord(vy[i]),
                  clamp_coord(vx[j]), clamp_coord(vy[j]), i == n - 1);
      end
    end
  endtask

  initial begin : stimulus
    logic [pipr_pkg::TOL_WIDTH-1:0] tol_plan[6];
    int seg_start;
    tol_plan[0] = 16'd0;
    tol_plan[1] = 16'hFFFF;
    tol_plan[2] = 16'($urandom_range(2, 64));
    tol_plan[3] = 16'($urandom_range(65535));
    tol_plan[4] = 16'd1;
    tol_plan[5] = 16'($urandom_range(0, 8));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // square around the query point, then the same square with the point outside
    send_edge(0, 0, -10, -10, 10, -10, 1'b0);
    send_edge(0, 0, 10, -10, 10, 10, 1'b0);
    send_edge(0, 0, 10, 10, -10, 10, 1'b0);
    send_edge(0, 0, -10, 10, -10, -10, 1'b1);
    send_edge(20, 0, -10, -10, 10, -10, 1'b0);
    send_edge(20, 0, 10, -10, 10, 10, 1'b0);
    send_edge(20, 0, 10, 10, -10, 10, 1'b0);
    send_edge(20, 0, -10, 10, -10, -10, 1'b1);
    send_edge(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
    send_edge(16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b1);
    // horizontal edge through the point, then a degenerate edge on the point
    send_edge(0, 5, -5, 5, 10, 5, 1'b1);
    send_edge(3, 3, 3, 3, 3, 3, 1'b1);

    // no edge is vertical: exact vertical still crosses, degenerate never does
    set_tolerance(16'd0);
    send_edge(0, 0, 10, -10, 10, 10, 1'b1);
    send_edge(3, 3, 3, 3, 3, 3, 1'b1);

    // widest tolerance: short horizontal counts as vertical, full-width one does not
    set_tolerance(16'hFFFF);
    send_edge(0, 5, -5, 5, 10, 5, 1'b1);
    send_edge(0, 0, -16'sd32768, 0, 16'sd32767, 0, 1'b1);

    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 6 : (seg < 4) ? 53 : 0;
      recv_stall_pct = (seg < 2) ? 53 : (seg < 4) ? 6 : 0;
      set_tolerance(tol_plan[seg]);
      seg_start = edges_sent;
      while (edges_sent - seg_start < SEGMENT_EDGES) begin
        send_random_polygon();
        if ($urandom_range(24) == 0) wait_for_answers();
      end
    end

    wait_for_answers();
    $display("Sent %0d edges in %0d polygons, %0d answers checked, %0d mismatches",
             edges_sent, polygons_sent, answers_checked, mismatches);
    $display("Tolerance written %0d times, including 0 and 65535, under three stall mixes",
             tol_writes);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
